[rtl/pfioc_pkg.sv]
// Package for the per-flow in-order check: payload words, table entry layout
// and controller state encoding. No dependencies.
`default_nettype none

package pfioc_pkg;

	// Input word: one bundle's flow key and creation time
	typedef struct packed {
		logic [63:0] source_node;
		logic [31:0] source_service;
		logic [63:0] dest_node;
		logic [31:0] dest_service;
		logic [31:0] creation_seconds;
		logic [31:0] creation_count;
	} in_word_t;

	// Output word: verdict for one bundle
	typedef struct packed {
		logic in_order;
		logic table_full;
	} out_word_t;

	// Flow key as stored in the table
	typedef struct packed {
		logic [63:0] source_node;
		logic [31:0] source_service;
		logic [63:0] dest_node;
		logic [31:0] dest_service;
	} flow_key_t;

	// Creation time, seconds compared first
	typedef struct packed {
		logic [31:0] seconds;
		logic [31:0] count;
	} flow_time_t;

	// One table entry
	typedef struct packed {
		flow_key_t  key;
		flow_time_t last;
	} flow_entry_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

[rtl/per_flow_in_order_check_unit.sv]
// Per-flow in-order check: flow table in one synchronous memory, scanned
// one entry per cycle. Depends on pfioc_pkg.
//
//  channel | dir | signals                      | payload type
//  --------+-----+------------------------------+----------------------
//  in      | in  | in_valid, in_ready, in_data  | pfioc_pkg::in_word_t
//  out     | out | out_valid, out_ready, out_data | pfioc_pkg::out_word_t
//
// One word is processed at a time. After accept the scan reads the stored
// entries from entry 0, stopping at the first key match or after checking
// all stored flows. The scan reads one entry per cycle through the single read
// port of the flow memory.
// Flows fill from entry 0 upward and are never removed, so a fill count
// marks the live entries; reset clears only the count and the control state.
// A new word is taken while the previous result still waits in the output
// register; the result is held until out_ready.
`default_nettype none

module per_flow_in_order_check_unit #(
	parameter int MAX_FLOWS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  pfioc_pkg::in_word_t  in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output pfioc_pkg::out_word_t out_data
);

	localparam int AW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
	localparam int CW = $clog2(MAX_FLOWS + 1);
	localparam logic [CW-1:0] FLOWS_C = CW'(MAX_FLOWS);

	// Flow table
	pfioc_pkg::flow_entry_t flow_mem [MAX_FLOWS];

	pfioc_pkg::state_t      state_q, state_d;
	pfioc_pkg::in_word_t    item_q;
	pfioc_pkg::flow_entry_t rd_entry_s1;
	logic                   pend_s1;
	logic [AW-1:0]          pidx_s1;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          count_q;
	logic                   hit_q;
	logic                   later_q;
	logic [AW-1:0]          hit_idx_q;
	logic                   out_valid_q;
	pfioc_pkg::out_word_t   out_data_q;

	pfioc_pkg::flow_key_t   item_key;
	pfioc_pkg::flow_entry_t wr_entry;
	logic                   match;
	logic                   later;
	logic                   issue;
	logic                   room;
	logic                   resp_fire;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic                   in_fire;

	// Key and time compare against the entry read last cycle
	always_comb begin
		item_key.source_node    = item_q.source_node;
		item_key.source_service = item_q.source_service;
		item_key.dest_node      = item_q.dest_node;
		item_key.dest_service   = item_q.dest_service;
		match = pend_s1 && (rd_entry_s1.key == item_key);
		later = (item_q.creation_seconds > rd_entry_s1.last.seconds) ||
			((item_q.creation_seconds == rd_entry_s1.last.seconds) &&
			 (item_q.creation_count > rd_entry_s1.last.count));
		room  = (count_q < FLOWS_C);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pfioc_pkg::ST_IDLE: begin
				if (in_valid) state_d = pfioc_pkg::ST_SCAN;
			end
			pfioc_pkg::ST_SCAN: begin
				if (match || (!pend_s1 && (idx_q == count_q))) state_d = pfioc_pkg::ST_RESP;
			end
			pfioc_pkg::ST_RESP: begin
				if (!out_valid_q || out_ready) state_d = pfioc_pkg::ST_IDLE;
			end
			default: state_d = pfioc_pkg::ST_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		in_ready  = (state_q == pfioc_pkg::ST_IDLE);
		in_fire   = in_ready && in_valid;
		issue     = (state_q == pfioc_pkg::ST_SCAN) && !match && (idx_q != count_q);
		resp_fire = (state_q == pfioc_pkg::ST_RESP) && (!out_valid_q || out_ready);
		wr_en     = resp_fire && (hit_q ? later_q : room);
		wr_addr   = hit_q ? hit_idx_q : count_q[AW-1:0];
		wr_entry.key          = item_key;
		wr_entry.last.seconds = item_q.creation_seconds;
		wr_entry.last.count   = item_q.creation_count;
	end

	// Memory: one write port, one registered read port. The write lands at
	// the edge that returns to idle, before the next scan reads.
	always_ff @(posedge clk) begin
		if (wr_en) flow_mem[wr_addr] <= wr_entry;
		if (issue) rd_entry_s1 <= flow_mem[idx_q[AW-1:0]];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) item_q <= in_data;
		if (issue) pidx_s1 <= idx_q[AW-1:0];
		if (match) begin
			later_q   <= later;
			hit_idx_q <= pidx_s1;
		end
		if (resp_fire) begin
			out_data_q.in_order   <= hit_q ? later_q : room;
			out_data_q.table_full <= !hit_q && !room;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfioc_pkg::ST_IDLE;
			pend_s1     <= 1'b0;
			idx_q       <= '0;
			count_q     <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (in_fire) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (match) hit_q <= 1'b1;
			if (resp_fire && !hit_q && room) count_q <= count_q + CW'(1);
			if (resp_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

[rtl/pfioc_chk.sv]
// Port-level checks for the per-flow in-order check, with the bind that
// attaches them to the top level. Depends on pfioc_pkg.
`default_nettype none

module pfioc_chk (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_valid,
	input wire                  in_ready,
	input pfioc_pkg::in_word_t  in_data,
	input wire                  out_valid,
	input wire                  out_ready,
	input pfioc_pkg::out_word_t out_data
);

	// A held result word must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// A full table never also reports in order
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.in_order && out_data.table_full))
		else $error("in_order and table_full both set");

	// One word at a time: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on back-to-back cycles");

	// An accept is not followed at once by a newly raised result
	a_res_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !(out_valid && !$past(out_valid)))
		else $error("result appeared the cycle after accept");

endmodule

bind per_flow_in_order_check_unit pfioc_chk u_pfioc_chk (.*);

`default_nettype wire
